// ----- rtl/core/pedigree_relationship_matrix_top_macros.svh -----
// ----------------------------------------------------------------------------
// pedigree relationship matrix assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef PEDIGREE_RELATIONSHIP_MATRIX_TOP_MACROS_SVH
`define PEDIGREE_RELATIONSHIP_MATRIX_TOP_MACROS_SVH

`ifndef SYNTH
`define PRM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define PRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PRM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PRM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/prm_pkg.sv -----
// ----------------------------------------------------------------------------
// prm_pkg
// shared types and defaults of the pedigree relationship matrix
// ----------------------------------------------------------------------------
`default_nettype none

package prm_pkg;

  localparam int DEF_MAX_INDIVIDUALS = 256;
  localparam int DEF_FRACTION_BITS   = 30;

  typedef enum logic [1:0] {
    FUNC_FOUNDER = 2'd0,
    FUNC_CHILD   = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/prm_req_if.sv -----
// ----------------------------------------------------------------------------
// prm_req_if
// request channel: function code and two individual indices
// ----------------------------------------------------------------------------
`default_nettype none

interface prm_req_if
  import prm_pkg::*;
();
  logic       valid;
  logic       ready;
  func_t      func;
  logic [7:0] first_index;
  logic [7:0] second_index;

  modport source (output valid, output func, output first_index, output second_index,
                  input ready);
  modport sink   (input valid, input func, input first_index, input second_index,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/prm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// prm_rsp_if
// response channel: status, new index and fixed-point value
// ----------------------------------------------------------------------------
`default_nettype none

interface prm_rsp_if
  import prm_pkg::*;
();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [7:0]  new_index;
  logic [31:0] value;

  modport source (output valid, output status, output new_index, output value,
                  input ready);
  modport sink   (input valid, input status, input new_index, input value,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/prm_ram.sv -----
// ----------------------------------------------------------------------------
// prm_ram
// generic simple dual-port ram, one write port, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module prm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/pedigree_relationship_matrix_top.sv -----
// ----------------------------------------------------------------------------
// pedigree_relationship_matrix_top
// additive relationship matrix by the tabular method, one individual per item
// ----------------------------------------------------------------------------
// Items are handled one at a time; ready is high only while the block is idle.
// For a child, the loop over earlier individuals runs through the single read
// port of the matrix ram: each earlier individual costs one read of the sire
// entry and one of the dam entry, while the write port stores the new row
// behind it. Only the lower triangle is kept (row index not below column
// index); a read with row below col is answered from the mirrored entry.
// The ram is not cleared after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pedigree_relationship_matrix_top_macros.svh"

module pedigree_relationship_matrix_top
  import prm_pkg::*;
#(
  parameter int MAX_INDIVIDUALS = DEF_MAX_INDIVIDUALS,
  parameter int FRACTION_BITS   = DEF_FRACTION_BITS
) (
  input wire logic clk,
  input wire logic rst,
  prm_req_if.sink  req,
  prm_rsp_if.source rsp
);

  localparam int IW    = $clog2(MAX_INDIVIDUALS);
  localparam int CNTW  = $clog2(MAX_INDIVIDUALS + 1);
  localparam int CMPW  = (CNTW > 8) ? CNTW : 8;
  localparam int DEPTH = MAX_INDIVIDUALS * MAX_INDIVIDUALS;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = FRACTION_BITS + 2;
  localparam logic [VW-1:0] FIXED_ONE = VW'(1) << FRACTION_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_ZERO, S_FILL_A, S_FILL_B, S_DRAIN, S_DIAG, S_RD_ISSUE, S_RD_DATA, S_RESP
  } state_t;

  function automatic logic [AW-1:0] cell_addr(logic [IW-1:0] r, logic [IW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_INDIVIDUALS) + AW'(c));
  endfunction

  function automatic logic [AW-1:0] pair_addr(logic [IW-1:0] x, logic [IW-1:0] y);
    return (x >= y) ? cell_addr(x, y) : cell_addr(y, x);
  endfunction

  state_t          state;
  logic [CNTW-1:0] count;
  logic [IW-1:0]   j;
  logic [IW-1:0]   wrj;
  logic [IW-1:0]   sire;
  logic [IW-1:0]   dam;
  logic            pend;
  logic [VW-1:0]   va;
  status_t         status;
  logic [7:0]      new_index;
  logic [31:0]     value;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [VW-1:0]   wdata;
  logic [AW-1:0]   raddr;
  logic [VW-1:0]   rdata;
  logic [IW-1:0]   n_idx;
  logic [VW:0]     sum_w;
  logic [VW-1:0]   half_sum;
  logic [VW-1:0]   diag_half;
  logic            full;
  logic            a_missing;
  logic            b_missing;

  assign n_idx     = IW'(count);
  assign sum_w     = {1'b0, va} + {1'b0, rdata};
  assign half_sum  = sum_w[VW:1];
  assign diag_half = rdata >> 1;
  assign full      = (count == CNTW'(MAX_INDIVIDUALS));
  assign a_missing = (CMPW'(req.first_index) >= CMPW'(count));
  assign b_missing = (CMPW'(req.second_index) >= CMPW'(count));

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = (state == S_RESP);
  assign rsp.status    = status;
  assign rsp.new_index = new_index;
  assign rsp.value     = value;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state)
      S_ZERO: begin
        we    = 1'b1;
        waddr = cell_addr(n_idx, j);
        wdata = (j == n_idx) ? FIXED_ONE : '0;
      end
      S_FILL_A: begin
        raddr = pair_addr(j, sire);
        we    = pend;
        waddr = cell_addr(n_idx, wrj);
        wdata = half_sum;
      end
      S_FILL_B: begin
        raddr = pair_addr(j, dam);
      end
      S_DRAIN: begin
        we    = 1'b1;
        waddr = cell_addr(n_idx, wrj);
        wdata = half_sum;
        raddr = pair_addr(sire, dam);
      end
      S_DIAG: begin
        we    = 1'b1;
        waddr = cell_addr(n_idx, n_idx);
        wdata = FIXED_ONE + diag_half;
      end
      S_RD_ISSUE: begin
        raddr = pair_addr(sire, dam);
      end
      default: ;
    endcase
  end

  prm_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            status    <= ST_OK;
            new_index <= '0;
            value     <= '0;
            j         <= '0;
            pend      <= 1'b0;
            sire      <= IW'(req.first_index);
            dam       <= IW'(req.second_index);
            unique case (req.func)
              FUNC_READ: begin
                if (a_missing || b_missing) begin
                  status <= ST_MISSING;
                  state  <= S_RESP;
                end else begin
                  state <= S_RD_ISSUE;
                end
              end
              FUNC_FOUNDER: begin
                if (full) begin
                  status <= ST_FULL;
                  state  <= S_RESP;
                end else begin
                  state <= S_ZERO;
                end
              end
              FUNC_CHILD: begin
                if (full) begin
                  status <= ST_FULL;
                  state  <= S_RESP;
                end else if (a_missing || b_missing) begin
                  status <= ST_MISSING;
                  state  <= S_RESP;
                end else begin
                  state <= S_FILL_A;
                end
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_ZERO: begin
          j <= j + 1'b1;
          if (j == n_idx) begin
            count     <= count + 1'b1;
            new_index <= 8'(count);
            state     <= S_RESP;
          end
        end
        S_FILL_A: begin
          state <= S_FILL_B;
        end
        S_FILL_B: begin
          va   <= rdata;
          wrj  <= j;
          pend <= 1'b1;
          j    <= j + 1'b1;
          if (IW'(j + 1'b1) == n_idx) begin
            state <= S_DRAIN;
          end else begin
            state <= S_FILL_A;
          end
        end
        S_DRAIN: begin
          pend  <= 1'b0;
          state <= S_DIAG;
        end
        S_DIAG: begin
          count     <= count + 1'b1;
          new_index <= 8'(count);
          value     <= 32'(diag_half);
          state     <= S_RESP;
        end
        S_RD_ISSUE: begin
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          value <= 32'(rdata);
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PRM_ASSERT_IMPLIES(a_ready_not_busy, clk, rst, req.ready, !rsp.valid)
  `PRM_ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= CNTW'(MAX_INDIVIDUALS))
  `PRM_ASSERT_NEXT(a_diag_adds_one, clk, rst, state == S_DIAG, count == $past(count) + 1'b1)
  `PRM_ASSERT_IMPLIES(a_write_row_new, clk, rst, we, state != S_IDLE && !full)

endmodule

`default_nettype wire

// ----- sim/pedigree_relationship_matrix_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pedigree_relationship_matrix_top_tb
// checks the relationship matrix block against an in-bench tabular builder
// ----------------------------------------------------------------------------
// Directed items cover an empty table, founders, children (sire equal to dam
// too), unknown indices, out-of-range reads and the unused code. Random items
// then grow the pedigree past a full table with mostly valid parents and
// reads. Requests and responses move in random bursts and stalls. A long
// response hold-off and a full drain are also exercised.
// ----------------------------------------------------------------------------

module pedigree_relationship_matrix_top_tb;
  import prm_pkg::*;

  localparam int          HERD_MAX   = DEF_MAX_INDIVIDUALS;
  localparam bit [31:0]   FIXED_ONE  = 32'd1 << DEF_FRACTION_BITS;
  localparam int          RANDOM_ITEMS = 800;
  localparam int          LONG_HOLD_CYCLES = 400;

  typedef struct {
    status_t     status;
    logic [7:0]  new_index;
    logic [31:0] value;
  } answer_t;

  class relationship_tracker;
    bit [31:0]   relation [0:HERD_MAX*HERD_MAX-1];
    int unsigned herd_size;
    answer_t     pending_answers[$];
    int unsigned failures, added, reads, full_hits, missing_hits, unused_hits;

    function void note_request(func_t f, logic [7:0] a, logic [7:0] b);
      answer_t     ans;
      bit [32:0]   sum;
      bit [31:0]   half;
      int unsigned n;
      n = herd_size;
      ans.status = ST_OK;
      ans.new_index = 8'd0;
      ans.value = 32'd0;
      if (f == FUNC_READ) begin
        if (a >= n || b >= n) begin
          ans.status = ST_MISSING;
          missing_hits++;
        end else begin
          ans.value = relation[a*HERD_MAX + b];
          reads++;
        end
      end else if (f == FUNC_NONE) begin
        unused_hits++;
      end else if (n >= HERD_MAX) begin
        ans.status = ST_FULL;
        full_hits++;
      end else if (f == FUNC_CHILD && (a >= n || b >= n)) begin
        ans.status = ST_MISSING;
        missing_hits++;
      end else begin
        for (int unsigned j = 0; j < n; j++) begin
          if (f == FUNC_FOUNDER) begin
            relation[j*HERD_MAX + n] = 32'd0;
            relation[n*HERD_MAX + j] = 32'd0;
          end else begin
            sum = {1'b0, relation[j*HERD_MAX + a]} + {1'b0, relation[j*HERD_MAX + b]};
            relation[j*HERD_MAX + n] = sum[32:1];
            relation[n*HERD_MAX + j] = sum[32:1];
          end
        end
        half = (f == FUNC_FOUNDER) ? 32'd0 : relation[a*HERD_MAX + b] >> 1;
        relation[n*HERD_MAX + n] = FIXED_ONE + half;
        ans.new_index = n[7:0];
        ans.value = half;
        herd_size = n + 1;
        added++;
      end
      pending_answers.insert(pending_answers.size(), ans);
    endfunction

    function void check_response(status_t s, logic [7:0] idx, logic [31:0] v);
      answer_t exp;
      if (pending_answers.size() == 0) begin
        $error("unexpected result: status %0d new_index %0d value 0x%08h", s, idx, v);
        failures++;
        return;
      end
      exp = pending_answers.pop_front();
      if (s !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, s);
        failures++;
      end
      if (idx !== exp.new_index) begin
        $error("new_index: expected %0d, actual %0d", exp.new_index, idx);
        failures++;
      end
      if (v !== exp.value) begin
        $error("value: expected 0x%08h, actual 0x%08h", exp.value, v);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  prm_req_if req_ch ();
  prm_rsp_if rsp_ch ();

  pedigree_relationship_matrix_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  relationship_tracker tracker;
  int          burst_left;
  bit          long_hold;
  int          hold_left;
  int unsigned rx_cycle;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // response side: check, then pick next ready
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      tracker.check_response(rsp_ch.status, rsp_ch.new_index, rsp_ch.value);
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (long_hold) begin
      long_hold = 1'b0;
      hold_left = LONG_HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      case (rx_cycle[9:8])
        2'd0:    rsp_ch.ready <= 1'b1;
        2'd1:    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        2'd2:    rsp_ch.ready <= (rx_cycle[2:0] != 3'd0);
        default: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  task automatic send_item(func_t f, logic [7:0] a, logic [7:0] b);
    int gap;
    req_ch.valid        <= 1'b1;
    req_ch.func         <= f;
    req_ch.first_index  <= a;
    req_ch.second_index <= b;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(f, a, b);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_pedigree();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_answers.size() != 0);
  endtask

  function automatic logic [7:0] pick_stored(bit recent);
    int unsigned n;
    n = tracker.herd_size;
    if (n == 0)
      return 8'($urandom_range(0, 255));
    if (recent)
      return 8'(n - 1 - $urandom_range(0, (n - 1 < 7) ? n - 1 : 7));
    return 8'($urandom_range(0, n - 1));
  endfunction

  task automatic send_random_item();
    int          r;
    func_t       f;
    logic [7:0]  a;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      f = func_t'($urandom_range(0, 3));
      a = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
    end else if (r < 20 || tracker.herd_size == 0) begin
      f = FUNC_FOUNDER;
      a = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
    end else if (r < 55) begin
      f = FUNC_CHILD;
      a = pick_stored(1'($urandom_range(0, 1)));
      b = ($urandom_range(0, 9) == 0) ? a : pick_stored(1'($urandom_range(0, 1)));
    end else begin
      f = FUNC_READ;
      a = pick_stored(1'b0);
      b = pick_stored(1'b0);
    end
    send_item(f, a, b);
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_NONE;
    req_ch.first_index = 8'd0;
    req_ch.second_index = 8'd0;
    rsp_ch.ready = 1'b0;
    long_hold = 1'b0;
    hold_left = 0;
    rx_cycle = 0;
    burst_left = 4;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, unused code, founders, children, bad indices
    send_item(FUNC_READ,    8'd0,   8'd0);
    send_item(FUNC_CHILD,   8'd0,   8'd0);
    send_item(FUNC_NONE,    8'd255, 8'd255);
    send_item(FUNC_FOUNDER, 8'd255, 8'd0);
    send_item(FUNC_FOUNDER, 8'd0,   8'd255);
    send_item(FUNC_CHILD,   8'd0,   8'd1);
    send_item(FUNC_CHILD,   8'd2,   8'd2);
    send_item(FUNC_CHILD,   8'd3,   8'd2);
    send_item(FUNC_CHILD,   8'd4,   8'd4);
    send_item(FUNC_CHILD,   8'd1,   8'd4);
    send_item(FUNC_CHILD,   8'd5,   8'd255);
    send_item(FUNC_CHILD,   8'd255, 8'd5);
    send_item(FUNC_CHILD,   8'd6,   8'd0);
    send_item(FUNC_READ,    8'd5,   8'd5);
    send_item(FUNC_READ,    8'd0,   8'd5);
    send_item(FUNC_READ,    8'd5,   8'd0);
    send_item(FUNC_READ,    8'd6,   8'd0);
    send_item(FUNC_READ,    8'd0,   8'd255);
    send_item(FUNC_READ,    8'd255, 8'd255);
    send_item(FUNC_NONE,    8'd0,   8'd0);
    drain_pedigree();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300)
        long_hold = 1'b1;
      if (i == 500)
        drain_pedigree();
      send_random_item();
    end

    req_ch.valid <= 1'b0;
    while (tracker.pending_answers.size() != 0) @(posedge clk);
    repeat (2 * HERD_MAX + 8) @(posedge clk);

    $display("run added %0d individuals (herd of %0d) and read %0d stored entries",
             tracker.added, tracker.herd_size, tracker.reads);
    $display("it also saw %0d full-table adds, %0d unknown indices, %0d unused codes",
             tracker.full_hits, tracker.missing_hits, tracker.unused_hits);
    if (tracker.failures == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/prm_pkg.sv
rtl/core/prm_req_if.sv
rtl/core/prm_rsp_if.sv
rtl/core/prm_ram.sv
rtl/core/pedigree_relationship_matrix_top.sv
sim/pedigree_relationship_matrix_top_tb.sv
